// ===== design/cms_pkg.sv =====
package cms_pkg;

  localparam int KEY_W      = 31;
  localparam int FUNC_W     = 2;
  localparam int AMT_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int OUT_CNT_W  = 16;
  localparam int OUT_DIST_W = 6;
  localparam int OUT_TOT_W  = 21;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t FN_ADD    = 2'd0;
  localparam func_t FN_REMOVE = 2'd1;
  localparam func_t FN_LOOKUP = 2'd2;

  localparam status_t STAT_DONE   = 2'd0;
  localparam status_t STAT_FULL   = 2'd1;
  localparam status_t STAT_ABSENT = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
    logic wr;
  } cell_ctl_t;

endpackage

// ===== design/counting_multiset_table.sv =====
// Channel  Direction  Handshake               Payload
// in_      request    in_valid / in_ready     func, key_value, amount
// out_     result     out_valid / out_ready   status, was_present, key_count,
//                                             distinct_keys, total_count
//
// Each request passes a compare state, in which every cell matches the key in
// parallel, then an update state that shifts or rewrites the row of cells.
// The result register lets the next request enter while a result waits.
// Synchronous active-low reset empties the table; no clearing pass is needed.
// A stalled result holds the update cycle until out_ready.
module counting_multiset_table #(
  parameter int TABLE_SLOTS = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cms_pkg::FUNC_W-1:0]      in_func,
  input  logic [cms_pkg::KEY_W-1:0]       in_key_value,
  input  logic [cms_pkg::AMT_W-1:0]       in_amount,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cms_pkg::STATUS_W-1:0]    out_status,
  output logic                            out_was_present,
  output logic [cms_pkg::OUT_CNT_W-1:0]   out_key_count,
  output logic [cms_pkg::OUT_DIST_W-1:0]  out_distinct_keys,
  output logic [cms_pkg::OUT_TOT_W-1:0]   out_total_count
);
  import cms_pkg::*;

  localparam int USED_W = $clog2(TABLE_SLOTS + 1);
  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int TOT_W  = COUNT_BITS + USED_W;
  localparam int SUM_W  = COUNT_BITS + AMT_W + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  state_t                state_r, state_nxt;
  logic [FUNC_W-1:0]     req_func_r;
  logic [KEY_W-1:0]      req_key_r;
  logic [AMT_W-1:0]      req_amt_r;
  logic [USED_W-1:0]     used_r, used_nxt;
  logic [TOT_W-1:0]      total_r, total_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic                  out_present_r;
  logic [OUT_CNT_W-1:0]  out_count_r;
  logic [OUT_DIST_W-1:0] out_dist_r;
  logic [OUT_TOT_W-1:0]  out_total_r;

  logic                  in_fire;
  logic                  cmp_en;
  logic                  upd_go;
  logic                  upd_fire;
  cell_ctl_t             cell_ctl;

  logic [KEY_W-1:0]      cell_key [TABLE_SLOTS];
  logic [COUNT_BITS-1:0] cell_cnt [TABLE_SLOTS];
  logic [COUNT_BITS-1:0] hit_cnt_a [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] hit_v;

  logic [COUNT_BITS-1:0] hit_cnt;
  logic [IDX_W-1:0]      hit_idx;
  logic                  found;
  logic [SUM_W-1:0]      sum;
  logic [COUNT_BITS-1:0] sat_cnt;
  logic [COUNT_BITS-1:0] added;
  logic [COUNT_BITS-1:0] new_count;
  logic                  do_ins, do_del, do_wr;
  logic [STATUS_W-1:0]   res_status;
  logic [COUNT_BITS-1:0] res_count;
  logic [USED_W-1:0]     res_used;
  logic [TOT_W-1:0]      res_total;

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    logic [KEY_W-1:0]      pk, nk;
    logic [COUNT_BITS-1:0] pc, nc;

    if (g == 0) begin : g_first
      assign pk = req_key_r;
      assign pc = new_count;
    end else begin : g_prev
      assign pk = cell_key[g-1];
      assign pc = cell_cnt[g-1];
    end

    if (g == TABLE_SLOTS - 1) begin : g_last
      assign nk = cell_key[g];
      assign nc = cell_cnt[g];
    end else begin : g_next
      assign nk = cell_key[g+1];
      assign nc = cell_cnt[g+1];
    end

    cms_cell #(
      .IDX        (g),
      .SLOTS      (TABLE_SLOTS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .req_key   (req_key_r),
      .used      (used_r),
      .hit_idx   (hit_idx),
      .new_count (new_count),
      .prev_key  (pk),
      .prev_cnt  (pc),
      .next_key  (nk),
      .next_cnt  (nc),
      .key_o     (cell_key[g]),
      .cnt_o     (cell_cnt[g]),
      .hit_o     (hit_v[g]),
      .hit_cnt_o (hit_cnt_a[g])
    );
  end

  always_comb begin
    hit_cnt = '0;
    hit_idx = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      hit_cnt = hit_cnt | hit_cnt_a[i];
      if (hit_v[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign found   = |hit_v;
  assign sum     = SUM_W'(hit_cnt) + SUM_W'(req_amt_r);
  assign sat_cnt = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : sum[COUNT_BITS-1:0];
  assign added   = sat_cnt - hit_cnt;

  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    do_wr      = 1'b0;
    new_count  = sat_cnt;
    res_status = STAT_DONE;
    res_count  = '0;
    res_used   = used_r;
    res_total  = total_r;
    case (req_func_r)
      FN_ADD: begin
        if (found) begin
          do_wr     = 1'b1;
          res_count = sat_cnt;
          res_total = total_r + TOT_W'(added);
        end else if (req_amt_r == '0) begin
          res_count = '0;
        end else if (used_r == USED_W'(TABLE_SLOTS)) begin
          res_status = STAT_FULL;
        end else begin
          do_ins    = 1'b1;
          res_count = sat_cnt;
          res_used  = used_r + USED_W'(1);
          res_total = total_r + TOT_W'(added);
        end
      end
      FN_REMOVE: begin
        if (!found) begin
          res_status = STAT_ABSENT;
        end else if (hit_cnt <= COUNT_BITS'(1)) begin
          do_del    = 1'b1;
          res_used  = used_r - USED_W'(1);
          res_total = total_r - TOT_W'(hit_cnt);
        end else begin
          do_wr     = 1'b1;
          new_count = hit_cnt - COUNT_BITS'(1);
          res_count = hit_cnt - COUNT_BITS'(1);
          res_total = total_r - TOT_W'(1);
        end
      end
      default: begin
        if (!found) begin
          res_status = STAT_ABSENT;
        end else begin
          res_count = hit_cnt;
        end
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_go) begin
          state_nxt = in_valid ? S_CMP : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    upd_go       = !out_valid_r || out_ready;
    cmp_en       = state_r == S_CMP;
    upd_fire     = (state_r == S_UPD) && upd_go;
    in_ready     = (state_r == S_IDLE) || upd_fire;
    cell_ctl.cmp = cmp_en;
    cell_ctl.ins = upd_fire && do_ins;
    cell_ctl.del = upd_fire && do_del;
    cell_ctl.wr  = upd_fire && do_wr;
  end

  assign in_fire       = in_valid && in_ready;
  assign used_nxt      = upd_fire ? res_used : used_r;
  assign total_nxt     = upd_fire ? res_total : total_r;
  assign out_valid_nxt = upd_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_func_r <= in_func;
      req_key_r  <= in_key_value;
      req_amt_r  <= in_amount;
    end
    if (upd_fire) begin
      out_status_r  <= res_status;
      out_present_r <= found;
      out_count_r   <= OUT_CNT_W'(res_count);
      out_dist_r    <= OUT_DIST_W'(res_used);
      out_total_r   <= OUT_TOT_W'(res_total);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_was_present   = out_present_r;
  assign out_key_count     = out_count_r;
  assign out_distinct_keys = out_dist_r;
  assign out_total_count   = out_total_r;

`ifndef SYNTH
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |-> $onehot0(hit_v))
    else $error("more than one slot matched the key");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(TABLE_SLOTS))
    else $error("occupied slot count beyond table size");

  a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire && do_del |=> used_r == $past(used_r) - USED_W'(1))
    else $error("freeing a slot did not drop the occupied count");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    used_r == '0 |-> total_r == '0)
    else $error("empty table with non-zero total");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire && res_status == STAT_FULL |-> used_r == USED_W'(TABLE_SLOTS))
    else $error("new key rejected while slots were free");
`endif

endmodule

// ===== design/cms_cell.sv =====
module cms_cell #(
  parameter int IDX        = 0,
  parameter int SLOTS      = 32,
  parameter int COUNT_BITS = 16,
  localparam int USED_W    = $clog2(SLOTS + 1),
  localparam int IDX_W     = $clog2(SLOTS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cms_pkg::cell_ctl_t         ctl,
  input  logic [cms_pkg::KEY_W-1:0]  req_key,
  input  logic [USED_W-1:0]          used,
  input  logic [IDX_W-1:0]           hit_idx,
  input  logic [COUNT_BITS-1:0]      new_count,
  input  logic [cms_pkg::KEY_W-1:0]  prev_key,
  input  logic [COUNT_BITS-1:0]      prev_cnt,
  input  logic [cms_pkg::KEY_W-1:0]  next_key,
  input  logic [COUNT_BITS-1:0]      next_cnt,
  output logic [cms_pkg::KEY_W-1:0]  key_o,
  output logic [COUNT_BITS-1:0]      cnt_o,
  output logic                       hit_o,
  output logic [COUNT_BITS-1:0]      hit_cnt_o
);
  import cms_pkg::*;

  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  hit_r, hit_nxt;
  logic                  occupied;
  logic                  shift_dn;

  assign occupied = USED_W'(IDX) < used;
  assign shift_dn = IDX_W'(IDX) >= hit_idx;

  always_comb begin
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    hit_nxt = hit_r;
    if (ctl.cmp) begin
      hit_nxt = occupied && (key_r == req_key);
    end
    if (ctl.ins) begin
      key_nxt = prev_key;
      cnt_nxt = prev_cnt;
    end else if (ctl.del && shift_dn) begin
      key_nxt = next_key;
      cnt_nxt = next_cnt;
    end else if (ctl.wr && hit_r) begin
      cnt_nxt = new_count;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign key_o     = key_r;
  assign cnt_o     = cnt_r;
  assign hit_o     = hit_r;
  assign hit_cnt_o = hit_r ? cnt_r : '0;

endmodule
